// ===== hw/rtl/lpt_pkg.sv =====
// Shared types and constants for the line position tracker.
`default_nettype none

package lpt_pkg;

    localparam int NUM_PROBES   = 6;
    localparam int PROBE_W      = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int ERR_W        = 8;
    localparam int COUNT_W      = 3;
    localparam int CENTER_W     = 4;
    localparam int LOSS_W       = 4;

    // doubled center of the array middle
    localparam logic [CENTER_W-1:0] MID_X2 = 4'd5;
    localparam int STEP_PER_HALF = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL     = 3'd0,
        CFG_ERROR_LIMIT      = 3'd1,
        CFG_CENTER_THRESHOLD = 3'd2,
        CFG_DEADBAND         = 3'd3,
        CFG_HOLD_FRAMES      = 3'd4,
        CFG_SMOOTH_STEP      = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        HINT_NONE  = 2'd0,
        HINT_LEFT  = 2'd1,
        HINT_RIGHT = 2'd2
    } t_hint;

    typedef logic [PROBE_W-1:0] t_probes [NUM_PROBES];

    typedef struct packed {
        logic [7:0] active_level;
        logic [6:0] error_limit;
        logic [6:0] center_threshold;
        logic [6:0] deadband;
        logic [3:0] hold_frames;
        logic [7:0] smooth_step;
    } t_cfg;

    typedef struct packed {
        logic [CENTER_W-1:0]     prev_center;
        logic signed [ERR_W-1:0] prev_error;
        logic [LOSS_W-1:0]       loss_count;
        logic                    center_known;
    } t_track_state;

    typedef struct packed {
        logic signed [ERR_W-1:0] position_error;
        logic [COUNT_W-1:0]      hit_count;
        logic                    line_seen;
        logic                    all_clear;
        t_hint                   corner_dir;
        logic                    centered;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/lpt_intf.sv =====
// Channel interfaces: probe frames in, tracking results out, register writes.
`default_nettype none

interface lpt_frame_if;
    logic                         valid;
    logic                         ready;
    logic [lpt_pkg::PROBE_W-1:0]  probe_0;
    logic [lpt_pkg::PROBE_W-1:0]  probe_1;
    logic [lpt_pkg::PROBE_W-1:0]  probe_2;
    logic [lpt_pkg::PROBE_W-1:0]  probe_3;
    logic [lpt_pkg::PROBE_W-1:0]  probe_4;
    logic [lpt_pkg::PROBE_W-1:0]  probe_5;

    modport source (output valid, probe_0, probe_1, probe_2, probe_3, probe_4, probe_5,
                    input ready);
    modport sink   (input valid, probe_0, probe_1, probe_2, probe_3, probe_4, probe_5,
                    output ready);
endinterface

interface lpt_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [lpt_pkg::ERR_W-1:0]   position_error;
    logic [lpt_pkg::COUNT_W-1:0]        hit_count;
    logic                               line_seen;
    logic                               all_clear;
    logic [1:0]                         corner_dir;
    logic                               centered;

    modport source (output valid, position_error, hit_count, line_seen, all_clear,
                    corner_dir, centered, input ready);
    modport sink   (input valid, position_error, hit_count, line_seen, all_clear,
                    corner_dir, centered, output ready);
endinterface

interface lpt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lpt_pkg::CFG_IDX_W-1:0]   index;
    logic [lpt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lpt_cfg_regs.sv =====
// Configuration register file with write decode.
`default_nettype none

module lpt_cfg_regs (
    input  wire            i_clk,
    input  wire            i_rst_n,
    lpt_cfg_if.sink        i_cfg,
    output lpt_pkg::t_cfg  o_cfg
);

    lpt_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level     <= 8'd1;
            r_cfg.error_limit      <= 7'd100;
            r_cfg.center_threshold <= 7'd10;
            r_cfg.deadband         <= 7'd5;
            r_cfg.hold_frames      <= 4'd5;
            r_cfg.smooth_step      <= 8'd20;
        end else if (i_cfg.valid) begin
            unique case (lpt_pkg::t_cfg_idx'(i_cfg.index))
                lpt_pkg::CFG_ACTIVE_LEVEL:     r_cfg.active_level     <= i_cfg.data;
                lpt_pkg::CFG_ERROR_LIMIT:      r_cfg.error_limit      <= i_cfg.data[6:0];
                lpt_pkg::CFG_CENTER_THRESHOLD: r_cfg.center_threshold <= i_cfg.data[6:0];
                lpt_pkg::CFG_DEADBAND:         r_cfg.deadband         <= i_cfg.data[6:0];
                lpt_pkg::CFG_HOLD_FRAMES:      r_cfg.hold_frames      <= i_cfg.data[3:0];
                lpt_pkg::CFG_SMOOTH_STEP:      r_cfg.smooth_step      <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lpt_frame_eval.sv =====
// Single-pass evaluation of one probe frame: run select, error, hint, smoothing.
`default_nettype none

module lpt_frame_eval (
    input  lpt_pkg::t_probes       i_probes,
    input  lpt_pkg::t_cfg          i_cfg,
    input  lpt_pkg::t_track_state  i_state,
    output lpt_pkg::t_result       o_result,
    output lpt_pkg::t_track_state  o_state
);

    localparam int NP = lpt_pkg::NUM_PROBES;

    logic [NP-1:0]                   act;
    logic [lpt_pkg::COUNT_W-1:0]     count;
    logic [lpt_pkg::CENTER_W-1:0]    best_c2;
    logic [lpt_pkg::CENTER_W-1:0]    c2;
    logic signed [lpt_pkg::ERR_W-1:0] raw;
    logic signed [lpt_pkg::ERR_W-1:0] err;
    lpt_pkg::t_hint                  hint;

    // active probes and their count
    always_comb begin
        count = '0;
        for (int i = 0; i < NP; i++) begin
            act[i] = (i_probes[i] == i_cfg.active_level);
            count  = count + lpt_pkg::COUNT_W'(act[i]);
        end
    end

    // walk the runs left to right, keep the longest, nearest to the reference
    always_comb begin
        logic [NP+1:0]                act_pad;
        logic [lpt_pkg::CENTER_W-1:0] ref_c2;
        logic [lpt_pkg::CENTER_W-1:0] run_start;
        logic [lpt_pkg::CENTER_W-1:0] sum;
        logic [lpt_pkg::CENTER_W-1:0] gap;
        logic [lpt_pkg::CENTER_W-1:0] len;
        logic [lpt_pkg::CENTER_W-1:0] best_len;
        logic [lpt_pkg::CENTER_W-1:0] best_dist;
        act_pad   = {1'b0, act, 1'b0};
        ref_c2    = i_state.center_known ? i_state.prev_center : lpt_pkg::MID_X2;
        run_start = '0;
        sum       = '0;
        gap       = '0;
        len       = '0;
        best_len  = '0;
        best_dist = '0;
        best_c2   = '0;
        for (int i = 0; i < NP; i++) begin
            if (act_pad[i+1] && !act_pad[i])
                run_start = lpt_pkg::CENTER_W'(i);
            if (act_pad[i+1] && !act_pad[i+2]) begin
                len  = lpt_pkg::CENTER_W'(i) - run_start + 4'd1;
                sum  = run_start + lpt_pkg::CENTER_W'(i);
                gap  = (sum >= ref_c2) ? (sum - ref_c2) : (ref_c2 - sum);
                if (best_len == '0 || len > best_len ||
                    (len == best_len && gap < best_dist)) begin
                    best_len  = len;
                    best_dist = gap;
                    best_c2   = sum;
                end
            end
        end
    end

    // raw error: 20 per half-probe, clamp, deadband
    always_comb begin
        logic signed [4:0] c_off;
        logic signed [8:0] raw_full;
        logic signed [8:0] lim;
        logic [8:0]        raw_mag;
        c2       = (count == lpt_pkg::COUNT_W'(NP)) ? lpt_pkg::MID_X2 : best_c2;
        c_off    = $signed({1'b0, c2}) - $signed({1'b0, lpt_pkg::MID_X2});
        raw_full = $signed({{4{c_off[4]}}, c_off}) * 9'(lpt_pkg::STEP_PER_HALF);
        lim      = $signed({2'b00, i_cfg.error_limit});
        if (raw_full > lim)
            raw_full = lim;
        if (raw_full < -lim)
            raw_full = -lim;
        raw_mag = raw_full[8] ? 9'(-raw_full) : 9'(raw_full);
        if (raw_mag <= {2'b00, i_cfg.deadband})
            raw_full = '0;
        raw = raw_full[lpt_pkg::ERR_W-1:0];
    end

    // sharp-turn hint
    always_comb begin
        logic left_edge;
        logic right_edge;
        logic mid;
        left_edge  = act[0] || act[1];
        right_edge = act[4] || act[5];
        mid        = act[2] || act[3];
        hint       = lpt_pkg::HINT_NONE;
        if (act[0] && act[1] && !right_edge)
            hint = lpt_pkg::HINT_LEFT;
        else if (act[4] && act[5] && !left_edge)
            hint = lpt_pkg::HINT_RIGHT;
        else if (mid && count >= 3'd3) begin
            if (left_edge && !right_edge)
                hint = lpt_pkg::HINT_LEFT;
            else if (right_edge && !left_edge)
                hint = lpt_pkg::HINT_RIGHT;
        end
    end

    // smoothing against the last error, divisions truncate toward zero
    always_comb begin
        logic signed [9:0] p;
        logic signed [9:0] r;
        logic signed [9:0] d;
        logic [9:0]        d_mag;
        logic signed [9:0] s3;
        logic signed [9:0] s2;
        logic signed [9:0] q;
        p     = 10'(i_state.prev_error);
        r     = 10'(raw);
        d     = r - p;
        d_mag = d[9] ? 10'(-d) : 10'(d);
        s3    = p + (p <<< 1) + r;
        s2    = p + r;
        if (d_mag <= {2'b00, i_cfg.smooth_step})
            q = s3[9] ? ((s3 + 10'sd3) >>> 2) : (s3 >>> 2);
        else
            q = s2[9] ? ((s2 + 10'sd1) >>> 1) : (s2 >>> 1);
        if (hint == lpt_pkg::HINT_NONE && i_state.center_known)
            err = q[lpt_pkg::ERR_W-1:0];
        else
            err = raw;
    end

    // result and next tracking state
    always_comb begin
        logic                      hold;
        logic [lpt_pkg::ERR_W-1:0] err_mag;
        hold    = i_state.center_known && (i_state.loss_count < i_cfg.hold_frames);
        err_mag = err[lpt_pkg::ERR_W-1] ? lpt_pkg::ERR_W'(-err) : lpt_pkg::ERR_W'(err);
        o_state = i_state;
        if (count == '0) begin
            if (hold)
                o_state.loss_count = i_state.loss_count + 4'd1;
            o_result.position_error = i_state.prev_error;
            o_result.hit_count      = '0;
            o_result.line_seen      = hold;
            o_result.all_clear      = !hold;
            o_result.corner_dir     = lpt_pkg::HINT_NONE;
            o_result.centered       = 1'b0;
        end else begin
            o_state.loss_count      = '0;
            o_state.prev_center     = c2;
            o_state.prev_error      = err;
            o_state.center_known    = 1'b1;
            o_result.position_error = err;
            o_result.hit_count      = count;
            o_result.line_seen      = 1'b1;
            o_result.all_clear      = 1'b0;
            o_result.corner_dir     = hint;
            o_result.centered       = (err_mag <= {1'b0, i_cfg.center_threshold}) &&
                                      (count >= 3'd2);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/line_position_tracker_core.sv =====
// Line position tracker: one six-probe frame in, one tracking result out.
//
// Channels: i_frame carries one frame of six probe readings per transaction,
// o_result one tracking result per frame, i_cfg register writes (index, data).
// The register channel is always ready; write only while the block is idle.
// Pipeline: a frame accepted on i_frame is captured in the input register;
// its result is loaded into the output register, and o_result.valid rises,
// once that register is empty or its result is being taken.
// Throughput: one frame per cycle while the receiver keeps up; the tracking
// state (last center, last error, loss count) is updated in the same cycle
// the result is registered, so the next frame sees it with no bubble.
// Reset (synchronous, active low) clears both stages, restores the register
// defaults and sets the tracking state to the array middle, error zero.
// Receiver stall: the result register holds; an empty input register still
// takes one more frame, then i_frame.ready drops until the result is taken.
`default_nettype none

module line_position_tracker_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lpt_frame_if.sink    i_frame,
    lpt_cfg_if.sink      i_cfg,
    lpt_result_if.source o_result
);

    lpt_pkg::t_cfg          cfg;
    lpt_pkg::t_probes       r_probes;
    logic                   r_in_valid;
    logic                   r_out_valid;
    lpt_pkg::t_result       r_result;
    lpt_pkg::t_result       n_result;
    lpt_pkg::t_track_state  r_state;
    lpt_pkg::t_track_state  n_state;
    logic                   advance;
    logic                   in_ready;

    lpt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    lpt_frame_eval u_eval (
        .i_probes (r_probes),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_result (n_result),
        .o_state  (n_state)
    );

    assign advance       = !r_out_valid || o_result.ready;
    assign in_ready      = !r_in_valid || advance;
    assign i_frame.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.valid && in_ready) begin
            r_probes[0] <= i_frame.probe_0;
            r_probes[1] <= i_frame.probe_1;
            r_probes[2] <= i_frame.probe_2;
            r_probes[3] <= i_frame.probe_3;
            r_probes[4] <= i_frame.probe_4;
            r_probes[5] <= i_frame.probe_5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_result <= n_result;
        end
    end

    // tracking state moves only when a frame moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prev_center  <= lpt_pkg::MID_X2;
            r_state.prev_error   <= '0;
            r_state.loss_count   <= '0;
            r_state.center_known <= 1'b0;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.position_error = r_result.position_error;
    assign o_result.hit_count      = r_result.hit_count;
    assign o_result.line_seen      = r_result.line_seen;
    assign o_result.all_clear      = r_result.all_clear;
    assign o_result.corner_dir     = r_result.corner_dir;
    assign o_result.centered       = r_result.centered;

endmodule

`default_nettype wire

// ===== hw/rtl/lpt_checker.sv =====
// Port-level checks for the line position tracker, bound to the top level.
`default_nettype none

module lpt_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_frame_ready,
    input wire                               i_res_valid,
    input wire                               i_res_ready,
    input wire signed [lpt_pkg::ERR_W-1:0]   i_res_error,
    input wire [lpt_pkg::COUNT_W-1:0]        i_res_count,
    input wire                               i_res_seen,
    input wire                               i_res_clear,
    input wire [1:0]                         i_res_hint,
    input wire                               i_res_centered
);

    // exactly one of line seen / all clear in every result
    a_seen_xor_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_seen != i_res_clear))
        else $error("line_seen and all_clear not complementary");

    // no active probes means no hint and never centered
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_count == '0) |->
        (i_res_hint == lpt_pkg::HINT_NONE && !i_res_centered))
        else $error("hint or centered on a frame with no active probe");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_clear) |-> (i_res_count == '0))
        else $error("all_clear with active probes");

    // a receiver that keeps up never throttles the frame side
    a_no_throttle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_ready |-> i_frame_ready)
        else $error("frame channel stalled while result side ready");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_error)))
        else $error("stalled result changed");

endmodule

bind line_position_tracker_core lpt_checker u_lpt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_frame_ready  (i_frame.ready),
    .i_res_valid    (o_result.valid),
    .i_res_ready    (o_result.ready),
    .i_res_error    (o_result.position_error),
    .i_res_count    (o_result.hit_count),
    .i_res_seen     (o_result.line_seen),
    .i_res_clear    (o_result.all_clear),
    .i_res_hint     (o_result.corner_dir),
    .i_res_centered (o_result.centered)
);

`default_nettype wire
